@@ rtl/fft_integer_convolution_core_defines.svh @@
// Assertion helpers for the convolution core
`ifndef FFT_INTEGER_CONVOLUTION_CORE_DEFINES_SVH
`define FFT_INTEGER_CONVOLUTION_CORE_DEFINES_SVH

`define FIC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define FIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fic_pkg.sv @@
package fic_pkg;
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CALC,
      ST_SEND
   } state_type;
   localparam int PROD_BITS = 21;
endpackage

@@ rtl/fic_ram.sv @@
module fic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/fft_integer_convolution_core.sv @@
// Sequencing: after the last input beat (c pairs held), each result beat is summed in ST_CALC
//   over the held pairs, then registered in ST_SEND; a stalled output holds the next result.
// Throughput: one input beat per cycle while loading; no new frame is taken until the last
//   result is registered; one shared multiply-accumulate per cycle while computing.
// Reset: synchronous, active high; clears state, count, valid, last, pend; RAM undefined.
`include "fft_integer_convolution_core_defines.svh"
module fft_integer_convolution_core #(
   parameter int MAX_POINTS = 64,
   parameter int COEF_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // a_coef[7:0], b_coef[15:8]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // product_coef[20:0], zeros above
   output logic        rsp_tlast
);
   localparam int HALF = MAX_POINTS / 2;
   localparam int AW   = $clog2(HALF);
   localparam int CW   = AW + 1;
   localparam int KW   = $clog2(MAX_POINTS) + 1;
   localparam int PW   = fic_pkg::PROD_BITS;

   fic_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] n_ff, n_in, k_ff, k_in;
   logic [CW-1:0] i_ff, i_in;
   logic          pend_ff, pend_in;       // product term in flight
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] out_ff, out_in;
   logic          vld_ff, vld_in, lst_ff, lst_in;

   logic [COEF_BITS-1:0] a_rd, b_rd;
   logic [AW-1:0]        ra, rb;
   logic                 wr_en, accept, term_ok;
   logic [KW-1:0]        kmi;

   assign accept = req_tvalid && req_tready;
   assign wr_en  = accept && (count_ff < CW'(HALF));
   assign kmi    = k_ff - KW'(i_ff);
   assign term_ok = (KW'(i_ff) <= k_ff) && (kmi < KW'(count_ff));
   assign ra = i_ff[AW-1:0];
   assign rb = kmi[AW-1:0];

   fic_ram #(.WIDTH(COEF_BITS), .DEPTH(HALF)) u_ram_a (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_tdata[COEF_BITS-1:0]), .rd_addr(ra), .rd_data(a_rd));
   fic_ram #(.WIDTH(COEF_BITS), .DEPTH(HALF)) u_ram_b (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_tdata[8+COEF_BITS-1:8]), .rd_addr(rb), .rd_data(b_rd));

   logic [PW-1:0] prod;
   assign prod = PW'(a_rd) * PW'(b_rd);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fic_pkg::ST_LOAD: if (accept && req_tlast) state_in = fic_pkg::ST_CALC;
         fic_pkg::ST_CALC: if (i_ff == count_ff && !pend_ff && (!vld_ff || rsp_tready))
            state_in = fic_pkg::ST_SEND;
         fic_pkg::ST_SEND: if (!vld_ff || rsp_tready) begin
            if (k_ff + KW'(1) == n_ff) state_in = fic_pkg::ST_LOAD;
            else state_in = fic_pkg::ST_CALC;
         end
         default: state_in = fic_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      n_in = n_ff; k_in = k_ff; i_in = i_ff; pend_in = 1'b0;
      acc_in = acc_ff; out_in = out_ff; vld_in = vld_ff; lst_in = lst_ff;
      req_tready = (state_ff == fic_pkg::ST_LOAD);
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         fic_pkg::ST_LOAD: begin
            if (wr_en) count_in = count_ff + CW'(1);
            if (accept && req_tlast) begin
               // smallest power of two not below twice the count
               n_in = KW'(2);
               for (int s = 2; s <= HALF; s = s * 2) begin
                  if (KW'(s / 2) < KW'(count_in)) n_in = KW'(2 * s);
               end
               k_in = '0; i_in = '0; acc_in = '0;
            end
         end
         fic_pkg::ST_CALC: begin
            if (pend_ff) acc_in = acc_ff + prod;
            if (i_ff != count_ff) begin
               pend_in = term_ok;
               i_in = i_ff + CW'(1);
            end
         end
         fic_pkg::ST_SEND: begin
            if (!vld_ff || rsp_tready) begin
               out_in = acc_ff; vld_in = 1'b1;
               lst_in = (k_ff + KW'(1) == n_ff);
               if (k_ff + KW'(1) == n_ff) count_in = '0;
               k_in = k_ff + KW'(1); i_in = '0; acc_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fic_pkg::ST_LOAD;
         count_ff <= '0; vld_ff <= 1'b0; lst_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; vld_ff <= vld_in; lst_ff <= lst_in; pend_ff <= pend_in;
      end
      n_ff <= n_in; k_ff <= k_in; i_ff <= i_in; acc_ff <= acc_in; out_ff <= out_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = 24'(out_ff);
   assign rsp_tlast  = lst_ff;

   `FIC_ASSERT_IMPL(a_no_ready_busy, clock, reset,
      state_ff != fic_pkg::ST_LOAD, !req_tready, "ready while busy")
   `FIC_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(HALF), "count overflow")
   `FIC_ASSERT_NEXT(a_last_to_calc, clock, reset, accept && req_tlast,
      state_ff == fic_pkg::ST_CALC, "last beat did not start compute")
endmodule

@@ dv/fic_checker.sv @@
module fic_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POINTS = 64;
   localparam int HALF = MAX_POINTS / 2;

   typedef struct packed {
      logic [fic_pkg::PROD_BITS-1:0] coef;
      logic                          last;
   } product_type;

   logic [7:0]  seq_a [HALF];
   logic [7:0]  seq_b [HALF];
   int          held;
   product_type product_q[$];

   // accumulate a sequence; on the last beat push the full linear convolution
   task automatic take_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
      int n;
      logic [31:0] acc;
      product_type p;
      if (held < HALF) begin
         seq_a[held] = a;
         seq_b[held] = b;
         held++;
      end
      if (last) begin
         n = 1;
         while (n < 2 * held) n = n * 2;
         for (int k = 0; k < n; k++) begin
            acc = 0;
            for (int i = 0; i < held; i++)
               if (i <= k && k - i < held) acc += seq_a[i] * seq_b[k - i];
            p.coef = acc[fic_pkg::PROD_BITS-1:0];
            p.last = (k == n - 1);
            product_q.push_back(p);
         end
         held = 0;
      end
   endtask

   always @(posedge clock) begin
      product_type want;
      if (reset) begin
         held = 0;
         product_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (product_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected beat: coef=%0d last=%0b", rsp_tdata[20:0], rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               want = product_q.pop_front();
               if (rsp_tdata !== {3'b0, want.coef} || rsp_tlast !== want.last) begin
                  if (fail_count < 10)
                     $display("mismatch: exp coef=%0d last=%0b got data=%0d last=%0b",
                              want.coef, want.last, rsp_tdata, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            take_pair(req_tdata[7:0], req_tdata[15:8], req_tlast);
      end
      pending <= product_q.size();
   end
endmodule

@@ dv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;

   int  send_idle = 0;
   int  sink_stall = 0;
   bit  hold_off = 0;
   int  quiet = 0;
   bit  timed_out = 0;

   always #10 clock = ~clock;

   fft_integer_convolution_core dut (.*);
   fic_checker chk (.*);

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("FAIL fft_integer_convolution_core");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= sink_stall);
   end

   task automatic send_beat(input logic [7:0] a, input logic [7:0] b, input logic last);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame(input int c, input int mode);
      logic [7:0] a, b;
      for (int i = 0; i < c; i++) begin
         case (mode)
            0: begin a = 8'($urandom); b = 8'($urandom); end
            1: begin a = 8'hff; b = 8'hff; end
            default: begin a = '0; b = '0; end
         endcase
         send_beat(a, b, i == c - 1);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int sent;
      int c;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: single pair, extremes, odd sizes, full and overflow
      send_beat(8'h00, 8'hff, 1);
      send_beat(8'hff, 8'h00, 1);
      send_beat(8'hff, 8'hff, 1);
      send_frame(2, 1);
      send_frame(3, 0);
      send_frame(2, 2);
      send_frame(5, 0);
      drain();
      send_frame(32, 1);
      send_frame(35, 0);
      drain();
      // backpressure: sink holds off while frames keep coming
      hold_off = 1;
      fork
         begin
            send_frame(6, 0);
            send_frame(4, 0);
         end
         begin
            repeat (2000) @(negedge clock);
            hold_off = 0;
         end
      join
      drain();
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle  = (phase == 1 || phase == 3) ? (phase == 1 ? 48 : 31) : 0;
         sink_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 48 : 31) : 0;
         while (sent < (phase + 1) * 95) begin
            c = ($urandom_range(9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 8);
            send_frame(c, $urandom_range(9) == 0 ? 1 : 0);
            sent += c;
         end
         drain();
      end
      send_idle = 0;
      sink_stall = 0;
      drain();
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS fft_integer_convolution_core");
      else
         $display("FAIL fft_integer_convolution_core");
      $finish;
   end
endmodule
